>>> rtl/arv_pkg.sv
`default_nettype none

package arv_pkg;

   // Field widths of the bar and the result
   localparam int PRICE_W     = 32;
   localparam int VOL_W       = 32;
   localparam int TR_W        = 32;
   localparam int ATR_W       = 40;
   localparam int ATR_FRAC    = 8;
   localparam int RELVOL_W    = 22;
   localparam int RELVOL_FRAC = 16;
   localparam int RELVOL_INT  = RELVOL_W - RELVOL_FRAC;

   // Default window lengths
   localparam int RANGE_WINDOW_DEF  = 14;
   localparam int VOLUME_WINDOW_DEF = 50;

   // Stream bus widths, whole bytes
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 96;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   localparam logic [RELVOL_W-1:0] RELVOL_ONE = RELVOL_W'(1) << RELVOL_FRAC;
   localparam logic [RELVOL_W-1:0] RELVOL_MAX = '1;

   // One classified bar as it waits for the back end
   typedef struct packed {
      logic [TR_W-1:0]  true_range;
      logic [VOL_W-1:0] volume;
   } bar_type;

endpackage

`default_nettype wire

>>> rtl/atr_and_relative_volume.sv
`default_nettype none

// Channel  Dir  Handshake              Payload (tdata, lowest bit first)
// -------  ---  ---------------------  ------------------------------------------
// req      in   req_tvalid/req_tready   high[31:0] low[63:32] close[95:64]
//                                       volume[127:96]
// rsp      out  rsp_tvalid/rsp_tready   true_range[31:0] atr[71:32] (8 frac bits)
//                                       relvol[93:72] (16 frac bits) zero[95:94]
//
// A bar is registered in the front register, where its true range forms,
// then waits in a two-entry queue. The back end reads the ring, updates the
// sums and multiplies, then forms the atr quotient in the 40-step restoring
// divider (the 22-step relvol divider runs alongside it). Reset is
// synchronous; no clearing pass runs, since the fill counts keep
// never-written ring entries unread.
// A stalled result holds in the output register while the next bar is
// accepted into the front and queue.
module atr_and_relative_volume #(
   parameter int RANGE_WINDOW  = arv_pkg::RANGE_WINDOW_DEF,
   parameter int VOLUME_WINDOW = arv_pkg::VOLUME_WINDOW_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // high, low, close, volume
   input  wire  [arv_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // true_range, atr, relvol, zero fill
   output logic [arv_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int PW = arv_pkg::PRICE_W;
   localparam int PAD_W = arv_pkg::RSP_DATA_W - arv_pkg::TR_W - arv_pkg::ATR_W -
                          arv_pkg::RELVOL_W;

   logic                              push_valid;
   logic                              push_ready;
   arv_pkg::bar_type                  push_bar;
   logic                              pop_valid;
   logic                              pop_ready;
   arv_pkg::bar_type                  pop_bar;
   logic [arv_pkg::TR_W-1:0]          out_tr;
   logic [arv_pkg::ATR_W-1:0]         out_atr;
   logic [arv_pkg::RELVOL_W-1:0]      out_relvol;

   // classify: register the bar, form its true range
   arv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_high   (req_tdata[PW-1:0]),
      .req_low    (req_tdata[2*PW-1:PW]),
      .req_close  (req_tdata[3*PW-1:2*PW]),
      .req_volume (req_tdata[3*PW+arv_pkg::VOL_W-1:3*PW]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_bar   (push_bar)
   );

   // hold classified bars while the back end divides
   arv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_bar   (push_bar),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_bar    (pop_bar)
   );

   // advance the rings, update sums, divide, register the result
   arv_back #(
      .RANGE_WINDOW  (RANGE_WINDOW),
      .VOLUME_WINDOW (VOLUME_WINDOW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_bar        (pop_bar),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_true_range (out_tr),
      .rsp_atr        (out_atr),
      .rsp_relvol     (out_relvol)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, out_relvol, out_atr, out_tr};

endmodule

`default_nettype wire

>>> rtl/arv_front.sv
`default_nettype none

module arv_front (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  [arv_pkg::PRICE_W-1:0]   req_high,
   input  wire  [arv_pkg::PRICE_W-1:0]   req_low,
   input  wire  [arv_pkg::PRICE_W-1:0]   req_close,
   input  wire  [arv_pkg::VOL_W-1:0]     req_volume,
   output logic                          push_valid,
   input  wire                           push_ready,
   output arv_pkg::bar_type              push_bar
);

   localparam int PW = arv_pkg::PRICE_W;

   logic [PW-1:0]               hi_ff;
   logic [PW-1:0]               lo_ff;
   logic [PW-1:0]               pc_ff;
   logic [arv_pkg::VOL_W-1:0]   vol_ff;
   logic [PW-1:0]               prev_close_ff;
   logic                        have_prev_ff;
   logic                        valid_ff;
   logic                        accept;
   logic [PW-1:0]               pc_in;
   logic [PW-1:0]               d_hl;
   logic [PW-1:0]               d_hp;
   logic [PW-1:0]               d_lp;
   logic [PW-1:0]               max_a;

   assign req_ready = !valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   // first bar compares against its own close
   assign pc_in = have_prev_ff ? prev_close_ff : req_close;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         have_prev_ff  <= 1'b0;
         prev_close_ff <= '0;
      end else begin
         if (accept) begin
            valid_ff      <= 1'b1;
            have_prev_ff  <= 1'b1;
            prev_close_ff <= req_close;
         end else if (push_ready) begin
            valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         hi_ff  <= req_high;
         lo_ff  <= req_low;
         pc_ff  <= pc_in;
         vol_ff <= req_volume;
      end
   end

   always_comb begin
      d_hl  = (hi_ff >= lo_ff) ? hi_ff - lo_ff : lo_ff - hi_ff;
      d_hp  = (hi_ff >= pc_ff) ? hi_ff - pc_ff : pc_ff - hi_ff;
      d_lp  = (lo_ff >= pc_ff) ? lo_ff - pc_ff : pc_ff - lo_ff;
      max_a = (d_hp > d_hl) ? d_hp : d_hl;
      push_bar.true_range = (d_lp > max_a) ? d_lp : max_a;
      push_bar.volume     = vol_ff;
   end

   assign push_valid = valid_ff;

endmodule

`default_nettype wire

>>> rtl/arv_queue.sv
`default_nettype none

module arv_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push_valid,
   output logic               push_ready,
   input  wire  arv_pkg::bar_type push_bar,
   output logic               pop_valid,
   input  wire                pop_ready,
   output arv_pkg::bar_type   pop_bar
);

   localparam int DEPTH = arv_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   arv_pkg::bar_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff;
   logic [PTR_W-1:0]   rd_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               push;
   logic               pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_bar    = entry_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + CNT_W'(1);
            2'b01:   count_ff <= count_ff - CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
      if (push) begin
         entry_ff[wr_ff] <= push_bar;
      end
   end

endmodule

`default_nettype wire

>>> rtl/arv_div.sv
`default_nettype none

// Restoring divider, one quotient bit a cycle. The caller guarantees the
// starting remainder is below the divisor, so QUO_W steps give the quotient.
module arv_div #(
   parameter int DVS_W = 6,
   parameter int QUO_W = 40
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire  [DVS_W-1:0]   rem_init,
   input  wire  [QUO_W-1:0]   num_low,
   input  wire  [DVS_W-1:0]   divisor,
   output logic               busy,
   output logic [QUO_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DVS_W-1:0]   rem_ff;
   logic [DVS_W-1:0]   dvs_ff;
   logic [QUO_W-1:0]   num_ff;
   logic [QUO_W-1:0]   quo_ff;
   logic [CNT_W-1:0]   left_ff;
   logic [DVS_W:0]     trial;
   logic [DVS_W+1:0]   diff;
   logic               take;

   assign trial = {rem_ff, num_ff[QUO_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};
   assign take  = !diff[DVS_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (start) begin
         left_ff <= CNT_W'(QUO_W);
      end else if (left_ff != '0) begin
         left_ff <= left_ff - CNT_W'(1);
      end
      if (start) begin
         rem_ff <= rem_init;
         num_ff <= num_low;
         dvs_ff <= divisor;
         quo_ff <= '0;
      end else if (left_ff != '0) begin
         rem_ff <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         num_ff <= num_ff << 1;
         quo_ff <= {quo_ff[QUO_W-2:0], take};
      end
   end

   assign busy     = left_ff != '0;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/arv_back.sv
`default_nettype none

module arv_back #(
   parameter int RANGE_WINDOW  = arv_pkg::RANGE_WINDOW_DEF,
   parameter int VOLUME_WINDOW = arv_pkg::VOLUME_WINDOW_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            pop_valid,
   output logic                           pop_ready,
   input  wire  arv_pkg::bar_type         pop_bar,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [arv_pkg::TR_W-1:0]       rsp_true_range,
   output logic [arv_pkg::ATR_W-1:0]      rsp_atr,
   output logic [arv_pkg::RELVOL_W-1:0]   rsp_relvol
);

   localparam int TW    = arv_pkg::TR_W;
   localparam int VW    = arv_pkg::VOL_W;
   localparam int AFRAC = arv_pkg::ATR_FRAC;
   localparam int RFRAC = arv_pkg::RELVOL_FRAC;
   localparam int RINT  = arv_pkg::RELVOL_INT;
   localparam int RF_W  = $clog2(RANGE_WINDOW + 1);
   localparam int VF_W  = $clog2(VOLUME_WINDOW + 1);
   localparam int RI_W  = (RANGE_WINDOW > 1) ? $clog2(RANGE_WINDOW) : 1;
   localparam int VI_W  = (VOLUME_WINDOW > 1) ? $clog2(VOLUME_WINDOW) : 1;
   localparam int RS_W  = TW + RF_W;
   localparam int VS_W  = VW + VF_W;
   localparam int PR_W  = VW + VF_W;
   localparam int CMP_W = VS_W + RINT;

   typedef enum logic [2:0] {
      B_IDLE,
      B_READ,
      B_ADD,
      B_START,
      B_WAIT
   } state_type;

   state_type          state_ff;
   logic [TW-1:0]      tr_ff;
   logic [VW-1:0]      vol_ff;
   logic [RS_W-1:0]    range_sum_ff;
   logic [RF_W-1:0]    range_fill_ff;
   logic [RI_W-1:0]    range_pos_ff;
   logic [VS_W-1:0]    volume_sum_ff;
   logic [VF_W-1:0]    volume_fill_ff;
   logic [VI_W-1:0]    volume_pos_ff;
   logic [PR_W-1:0]    prod_ff;
   logic               vol_zero_ff;
   logic               vol_sat_ff;
   logic               rsp_valid_ff;
   logic [TW-1:0]      rsp_tr_ff;
   logic [arv_pkg::ATR_W-1:0]    rsp_atr_ff;
   logic [arv_pkg::RELVOL_W-1:0] rsp_relvol_ff;

   logic [TW-1:0]      range_mem [RANGE_WINDOW];
   logic [VW-1:0]      volume_mem [VOLUME_WINDOW];
   logic [TW-1:0]      range_rd_ff;
   logic [VW-1:0]      volume_rd_ff;
   logic               mem_we;

   logic               vol_zero_in;
   logic               vol_sat_in;
   logic               atr_start;
   logic               rv_start;
   logic               atr_busy;
   logic               rv_busy;
   logic [arv_pkg::ATR_W-1:0]    atr_quo;
   logic [arv_pkg::RELVOL_W-1:0] rv_quo;
   logic               out_load;

   // ring memories: one write, one registered read at the ring position
   assign mem_we = state_ff == B_READ;

   always_ff @(posedge clock) begin
      range_rd_ff  <= range_mem[range_pos_ff];
      volume_rd_ff <= volume_mem[volume_pos_ff];
      if (mem_we) begin
         range_mem[range_pos_ff]   <= tr_ff;
         volume_mem[volume_pos_ff] <= vol_ff;
      end
   end

   // quotient of relvol reaches 2^22 exactly when volume * fill >= sum * 64
   assign vol_zero_in = volume_sum_ff == '0;
   assign vol_sat_in  = CMP_W'(prod_ff) >= {volume_sum_ff, {RINT{1'b0}}};
   assign atr_start   = state_ff == B_START;
   assign rv_start    = atr_start && !vol_zero_in && !vol_sat_in;
   assign out_load    = (state_ff == B_WAIT) && !atr_busy && !rv_busy &&
                        (!rsp_valid_ff || rsp_ready);
   assign pop_ready   = state_ff == B_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_IDLE;
         range_sum_ff   <= '0;
         range_fill_ff  <= '0;
         range_pos_ff   <= '0;
         volume_sum_ff  <= '0;
         volume_fill_ff <= '0;
         volume_pos_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  tr_ff    <= pop_bar.true_range;
                  vol_ff   <= pop_bar.volume;
                  state_ff <= B_READ;
               end
            end
            B_READ: begin
               // drop the oldest entry once the window is full
               if (range_fill_ff == RF_W'(RANGE_WINDOW)) begin
                  range_sum_ff <= range_sum_ff - RS_W'(range_rd_ff);
               end else begin
                  range_fill_ff <= range_fill_ff + RF_W'(1);
               end
               if (volume_fill_ff == VF_W'(VOLUME_WINDOW)) begin
                  volume_sum_ff <= volume_sum_ff - VS_W'(volume_rd_ff);
               end else begin
                  volume_fill_ff <= volume_fill_ff + VF_W'(1);
               end
               range_pos_ff  <= (range_pos_ff == RI_W'(RANGE_WINDOW - 1)) ?
                                '0 : range_pos_ff + RI_W'(1);
               volume_pos_ff <= (volume_pos_ff == VI_W'(VOLUME_WINDOW - 1)) ?
                                '0 : volume_pos_ff + VI_W'(1);
               state_ff <= B_ADD;
            end
            B_ADD: begin
               range_sum_ff  <= range_sum_ff + RS_W'(tr_ff);
               volume_sum_ff <= volume_sum_ff + VS_W'(vol_ff);
               prod_ff       <= PR_W'(vol_ff) * PR_W'(volume_fill_ff);
               state_ff      <= B_START;
            end
            B_START: begin
               vol_zero_ff <= vol_zero_in;
               vol_sat_ff  <= vol_sat_in;
               state_ff    <= B_WAIT;
            end
            B_WAIT: begin
               if (out_load) begin
                  rsp_tr_ff     <= tr_ff;
                  rsp_atr_ff    <= atr_quo;
                  rsp_relvol_ff <= vol_zero_ff ? arv_pkg::RELVOL_ONE :
                                   vol_sat_ff  ? arv_pkg::RELVOL_MAX : rv_quo;
                  state_ff      <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // atr = sum * 256 / fill; the sum never reaches fill * 2^32
   arv_div #(
      .DVS_W (RF_W),
      .QUO_W (arv_pkg::ATR_W)
   ) u_atr_div (
      .clock    (clock),
      .reset    (reset),
      .start    (atr_start),
      .rem_init (range_sum_ff[RS_W-1:TW]),
      .num_low  ({range_sum_ff[TW-1:0], {AFRAC{1'b0}}}),
      .divisor  (range_fill_ff),
      .busy     (atr_busy),
      .quotient (atr_quo)
   );

   // relvol = volume * fill * 65536 / sum, started only below saturation
   arv_div #(
      .DVS_W (VS_W),
      .QUO_W (arv_pkg::RELVOL_W)
   ) u_rv_div (
      .clock    (clock),
      .reset    (reset),
      .start    (rv_start),
      .rem_init (VS_W'(prod_ff >> RINT)),
      .num_low  ({prod_ff[RINT-1:0], {RFRAC{1'b0}}}),
      .divisor  (volume_sum_ff),
      .busy     (rv_busy),
      .quotient (rv_quo)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_true_range = rsp_tr_ff;
   assign rsp_atr        = rsp_atr_ff;
   assign rsp_relvol     = rsp_relvol_ff;

endmodule

`default_nettype wire

>>> rtl/arv_checker.sv
`default_nettype none

module arv_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire [arv_pkg::REQ_DATA_W-1:0]   req_tdata,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [arv_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // front register, two queue entries, back end, output register
   localparam logic [2:0] MAX_INFLIGHT = 3'd5;

   logic [2:0]  pending_ff;
   logic        first_ff;
   logic        req_acc;
   logic        rsp_acc;
   logic [arv_pkg::REQ_DATA_W-1:0] req_seen;

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_acc  = rsp_tvalid && rsp_tready;
   assign req_seen = req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         first_ff   <= 1'b1;
      end else begin
         case ({req_acc, rsp_acc})
            2'b10:   pending_ff <= pending_ff + 3'd1;
            2'b01:   pending_ff <= pending_ff - 3'd1;
            default: pending_ff <= pending_ff;
         endcase
         if (rsp_acc) begin
            first_ff <= 1'b0;
         end
      end
   end

   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 3'd0)
      else $error("result without an outstanding request");

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      (req_seen == req_seen) |-> pending_ff <= MAX_INFLIGHT)
      else $error("more requests in flight than the design can hold");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_first_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && first_ff |->
         (rsp_tdata[71:32] == {rsp_tdata[31:0], 8'h00}) &&
         (rsp_tdata[93:72] == 22'h010000))
      else $error("first result after reset is not a one-bar window");

endmodule

bind atr_and_relative_volume arv_checker u_arv_checker (.*);

`default_nettype wire
